### sv/pfa_pkg.sv
// Shared definitions for the page frame allocator.
// Operation and status codes, port widths, default sizes, config struct.
// No dependencies.
`default_nettype none
package pfa_pkg;

	localparam int DEF_NUM_BLOCKS  = 4096;
	localparam int DEF_BLOCK_BYTES = 4096;

	localparam int ADDR_W   = 24;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;
	localparam int APB_AW   = 3;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM          = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd4;

	// word index of a register, taken from paddr[2]
	localparam logic REG_RESERVED = 1'b0;

	localparam logic [COUNT_W-1:0] RESERVED_RST = 13'd1;

	typedef struct packed {
		logic [COUNT_W-1:0] reserved_blocks;
	} pfa_cfg_t;

endpackage
`default_nettype wire

### sv/pfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/pfa_cfg.sv
// APB register block of the page frame allocator: reserved_blocks.
// Depends on pfa_pkg.
`default_nettype none
module pfa_cfg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire  [pfa_pkg::APB_AW-1:0] paddr,
	input  wire  [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output pfa_pkg::pfa_cfg_t          cfg
);

	logic [pfa_pkg::COUNT_W-1:0] reserved_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= pfa_pkg::RESERVED_RST;
		end else if (wr_en && paddr[2] == pfa_pkg::REG_RESERVED) begin
			reserved_q <= pwdata[pfa_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pfa_pkg::REG_RESERVED) begin
			prdata = 32'(reserved_q);
		end
	end

	assign cfg.reserved_blocks = reserved_q;

endmodule
`default_nettype wire

### sv/pfa_core.sv
// Allocator engine: sequencer over the free stack and occupancy bitmap RAMs,
// free count, result holding and output registers.
// Depends on pfa_pkg and pfa_ram.
`default_nettype none
module pfa_core #(
	parameter int NUM_BLOCKS  = pfa_pkg::DEF_NUM_BLOCKS,
	parameter int BLOCK_BYTES = pfa_pkg::DEF_BLOCK_BYTES
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pfa_pkg::pfa_cfg_t            cfg,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  wire  [pfa_pkg::OP_W-1:0]     req_op,
	input  wire  [pfa_pkg::ADDR_W-1:0]   req_addr,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output logic [pfa_pkg::STATUS_W-1:0] rsp_status,
	output logic [pfa_pkg::ADDR_W-1:0]   rsp_addr,
	output logic [pfa_pkg::COUNT_W-1:0]  rsp_count
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int BW = $clog2(BLOCK_BYTES);
	localparam int XW = IW + pfa_pkg::ADDR_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_INIT  = 3'd3;
	localparam logic [2:0] S_HOLD  = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] free_q, free_d;
	logic          init_done_q, init_done_d;
	logic [IW-1:0] blk_q, blk_d;
	logic [CW-1:0] res_q, res_d;
	logic [IW-1:0] idx_q, idx_d;

	logic [pfa_pkg::STATUS_W-1:0] hold_status_q;
	logic [pfa_pkg::ADDR_W-1:0]   hold_addr_q;
	logic [pfa_pkg::COUNT_W-1:0]  hold_count_q;
	logic                         out_valid_q;
	logic [pfa_pkg::STATUS_W-1:0] out_status_q;
	logic [pfa_pkg::ADDR_W-1:0]   out_addr_q;
	logic [pfa_pkg::COUNT_W-1:0]  out_count_q;

	logic                         fin;
	logic [pfa_pkg::STATUS_W-1:0] fin_status;
	logic [pfa_pkg::ADDR_W-1:0]   fin_addr;
	logic [pfa_pkg::COUNT_W-1:0]  fin_count;
	logic                         out_free;

	logic          stk_we, stk_re, occ_we, occ_re, occ_wdata;
	logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
	logic [IW-1:0] occ_waddr, occ_raddr;
	logic          occ_rdata;

	logic          acc, misal, out_rng, keep, last;
	logic [XW-1:0] blk_wide;
	logic [IW-1:0] blk_in;
	logic [CW-1:0] res_sat;
	logic [IW+BW-1:0] alloc_prod;
	logic [CW+BW-1:0] init_prod;

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;

	assign misal    = |req_addr[BW-1:0];
	assign blk_wide = {IW'(0), req_addr} >> BW;
	assign out_rng  = blk_wide >= XW'(NUM_BLOCKS);
	assign blk_in   = blk_wide[IW-1:0];
	assign res_sat  = (32'(cfg.reserved_blocks) > 32'(NUM_BLOCKS)) ?
		CW'(NUM_BLOCKS) : CW'(cfg.reserved_blocks);

	assign keep       = (CW+1)'(blk_q) < (CW+1)'(res_q);
	assign last       = blk_q == IW'(NUM_BLOCKS - 1);
	assign alloc_prod = {stk_rdata, BW'(0)};
	assign init_prod  = {res_q, BW'(0)};

	always_comb begin
		state_d     = state_q;
		free_d      = free_q;
		init_done_d = init_done_q;
		blk_d       = blk_q;
		res_d       = res_q;
		idx_d       = idx_q;
		fin         = 1'b0;
		fin_status  = pfa_pkg::ST_OK;
		fin_addr    = '0;
		stk_we      = 1'b0;
		stk_waddr   = IW'(free_q);
		stk_wdata   = blk_q;
		stk_re      = 1'b0;
		stk_raddr   = IW'(free_q - CW'(1));
		occ_we      = 1'b0;
		occ_waddr   = blk_q;
		occ_wdata   = 1'b0;
		occ_re      = 1'b0;
		occ_raddr   = blk_in;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req_op)
						pfa_pkg::OP_ALLOC: begin
							if (free_q == '0) begin
								fin        = 1'b1;
								fin_status = pfa_pkg::ST_OOM;
							end else begin
								stk_re  = 1'b1;
								free_d  = free_q - CW'(1);
								state_d = S_ALLOC;
							end
						end
						pfa_pkg::OP_FREE: begin
							if (misal) begin
								fin        = 1'b1;
								fin_status = pfa_pkg::ST_MISALIGNED;
							end else if (out_rng) begin
								fin        = 1'b1;
								fin_status = pfa_pkg::ST_RANGE;
							end else begin
								occ_re  = 1'b1;
								idx_d   = blk_in;
								state_d = S_FREE;
							end
						end
						pfa_pkg::OP_INIT: begin
							res_d       = res_sat;
							free_d      = '0;
							blk_d       = '0;
							init_done_d = 1'b1;
							state_d     = S_INIT;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				occ_we    = 1'b1;
				occ_waddr = stk_rdata;
				occ_wdata = 1'b1;
				fin       = 1'b1;
				fin_addr  = pfa_pkg::ADDR_W'(alloc_prod);
			end
			S_FREE: begin
				fin = 1'b1;
				if (occ_rdata && init_done_q) begin
					occ_we    = 1'b1;
					occ_waddr = idx_q;
					if (free_q != CW'(NUM_BLOCKS)) begin
						stk_we    = 1'b1;
						stk_wdata = idx_q;
						free_d    = free_q + CW'(1);
					end
				end else begin
					fin_status = pfa_pkg::ST_ALREADY_FREE;
				end
			end
			S_INIT: begin
				occ_we    = 1'b1;
				occ_wdata = keep;
				if (!keep) begin
					stk_we = 1'b1;
					free_d = free_q + CW'(1);
				end
				blk_d = blk_q + IW'(1);
				if (last) begin
					fin      = 1'b1;
					fin_addr = pfa_pkg::ADDR_W'(init_prod);
				end
			end
			S_HOLD: begin
				fin        = 1'b1;
				fin_status = hold_status_q;
				fin_addr   = hold_addr_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	assign fin_count = (state_q == S_HOLD) ? hold_count_q : pfa_pkg::COUNT_W'(free_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= '0;
			init_done_q <= 1'b0;
			blk_q       <= '0;
			res_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_q      <= free_d;
			init_done_q <= init_done_d;
			blk_q       <= blk_d;
			res_q       <= res_d;
			idx_q       <= idx_d;
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			out_status_q <= fin_status;
			out_addr_q   <= fin_addr;
			out_count_q  <= fin_count;
		end
		if (fin && !out_free) begin
			hold_status_q <= fin_status;
			hold_addr_q   <= fin_addr;
			hold_count_q  <= fin_count;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_addr   = out_addr_q;
	assign rsp_count  = out_count_q;

	pfa_ram #(
		.WIDTH(IW),
		.DEPTH(NUM_BLOCKS)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	pfa_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BLOCKS)
	) u_bitmap (
		.clk  (clk),
		.we   (occ_we),
		.waddr(occ_waddr),
		.wdata(occ_wdata),
		.re   (occ_re),
		.raddr(occ_raddr),
		.rdata(occ_rdata)
	);

endmodule
`default_nettype wire

### sv/page_frame_allocator_unit.sv
// Page frame allocator top level: stream request/response ports, APB config.
// Depends on pfa_pkg, pfa_cfg, pfa_core (and pfa_ram below it).
//
// Hands out and takes back fixed-size physical blocks. Requests carry an
// operation in s_tuser (allocate, free, initialize); every request gives
// exactly one response, status in m_tuser. Allocate and a free that passes
// the address checks first do the synchronous read of the free stack or the
// occupancy bitmap, then the write-back. A free rejected as misaligned or out
// of range, an allocate with nothing free and an unused code finish in the
// cycle that accepts them. Initialize, after its accepting cycle, walks every
// block once, one per cycle. One request is worked on at a time; a finished
// response waits in the output register (and one holding stage behind it),
// so a new request is taken while the previous response is still pending.
// While the holding stage is in use no request is taken. Until the first
// initialize nothing is free and nothing is occupied; no clearing pass runs
// after reset.
`default_nettype none
module page_frame_allocator_unit #(
	parameter int NUM_BLOCKS  = pfa_pkg::DEF_NUM_BLOCKS,
	parameter int BLOCK_BYTES = pfa_pkg::DEF_BLOCK_BYTES
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [23:0]                s_tdata,  // byte_address
	input  wire  [1:0]                 s_tuser,  // operation
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [39:0]                m_tdata,  // block_address, free_count, zero pad
	output logic [2:0]                 m_tuser,  // status
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire  [pfa_pkg::APB_AW-1:0] paddr,
	input  wire  [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	pfa_pkg::pfa_cfg_t            cfg;
	logic [pfa_pkg::ADDR_W-1:0]   rsp_addr;
	logic [pfa_pkg::COUNT_W-1:0]  rsp_count;

	pfa_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	pfa_core #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (s_tuser),
		.req_addr  (s_tdata),
		.rsp_valid (m_tvalid),
		.rsp_ready (m_tready),
		.rsp_status(m_tuser),
		.rsp_addr  (rsp_addr),
		.rsp_count (rsp_count)
	);

	assign m_tdata = {3'b000, rsp_count, rsp_addr};

	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pfa_pkg::ST_OOM |-> m_tdata[36:24] == 13'd0)
		else $error("out of memory reported with blocks still free");

	a_err_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pfa_pkg::ST_OK |-> m_tdata[23:0] == 24'd0)
		else $error("error response carries a block address");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (NUM_BLOCKS > 8191) || (32'(m_tdata[36:24]) <= 32'(NUM_BLOCKS)))
		else $error("free count above number of blocks");

	a_busy_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == pfa_pkg::OP_INIT |=> !s_tready)
		else $error("request taken during initialize walk");

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for page_frame_allocator_unit: directed and random allocate, free and
// initialize requests under random stalls, checked field by field against a bench model.
// Depends on pfa_pkg and the allocator RTL; needs no files or arguments.
module tb;

	localparam int NBLK      = pfa_pkg::DEF_NUM_BLOCKS;
	localparam int BLK_BYTES = pfa_pkg::DEF_BLOCK_BYTES;
	localparam int N_ITEMS   = 600;
	localparam logic [pfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [pfa_pkg::STATUS_W-1:0] status;
		logic [pfa_pkg::ADDR_W-1:0]   block_address;
		logic [pfa_pkg::COUNT_W-1:0]  free_count;
	} frame_resp_t;

	class frame_ledger;
		bit                          occupied[NBLK];
		logic [11:0]                 free_stack[NBLK];
		int unsigned                 free_n;
		logic [pfa_pkg::COUNT_W-1:0] reserved;
		int unsigned                 held[$];
		frame_resp_t                 expected_q[$];
		int unsigned                 requests;
		int unsigned                 responses;
		int unsigned                 mismatches;
		int unsigned                 status_seen[5];

		function new();
			int b;
			for (b = 0; b < NBLK; b++) begin
				occupied[b]   = 1'b0;
				free_stack[b] = '0;
			end
			free_n   = 0;
			reserved = pfa_pkg::RESERVED_RST;
		endfunction

		function void flag(string msg);
			if (mismatches < 10)
				$display("MISMATCH %s", msg);
			mismatches++;
		endfunction

		function frame_resp_t predict_response(logic [pfa_pkg::OP_W-1:0] op,
			logic [pfa_pkg::ADDR_W-1:0] addr);
			frame_resp_t r;
			int unsigned blk;
			int unsigned res;
			int unsigned n;
			int b;
			int i;
			r.status        = pfa_pkg::ST_OK;
			r.block_address = '0;
			case (op)
			pfa_pkg::OP_ALLOC: begin
				if (free_n == 0) begin
					r.status = pfa_pkg::ST_OOM;
				end else begin
					free_n--;
					blk           = free_stack[free_n];
					occupied[blk] = 1'b1;
					held.push_back(blk);
					r.block_address = 24'(longint'(blk) * BLK_BYTES);
				end
			end
			pfa_pkg::OP_FREE: begin
				blk = addr / BLK_BYTES;
				if (addr % BLK_BYTES != 0) begin
					r.status = pfa_pkg::ST_MISALIGNED;
				end else if (blk >= NBLK) begin
					r.status = pfa_pkg::ST_RANGE;
				end else if (!occupied[blk]) begin
					r.status = pfa_pkg::ST_ALREADY_FREE;
				end else begin
					occupied[blk] = 1'b0;
					for (i = 0; i < held.size(); i++) begin
						if (held[i] == blk) begin
							held.delete(i);
							break;
						end
					end
					if (free_n < NBLK) begin
						free_stack[free_n] = 12'(blk);
						free_n++;
					end
				end
			end
			pfa_pkg::OP_INIT: begin
				res = reserved;
				if (res > NBLK)
					res = NBLK;
				n = 0;
				held.delete();
				for (b = 0; b < NBLK; b++) begin
					if (b < res) begin
						occupied[b] = 1'b1;
					end else begin
						occupied[b]   = 1'b0;
						free_stack[n] = 12'(b);
						n++;
					end
				end
				free_n          = n;
				r.block_address = 24'(longint'(res) * BLK_BYTES);
			end
			default: ;
			endcase
			r.free_count = free_n[pfa_pkg::COUNT_W-1:0];
			return r;
		endfunction

		function void note_request(logic [pfa_pkg::OP_W-1:0] op,
			logic [pfa_pkg::ADDR_W-1:0] addr);
			expected_q.push_back(predict_response(op, addr));
			requests++;
		endfunction

		function void check_response(frame_resp_t got);
			frame_resp_t exp;
			if (got.status < 5)
				status_seen[got.status]++;
			if (expected_q.size() == 0) begin
				flag($sformatf("response %0d arrived with none expected: %s",
					responses, $sformatf("st=%0d addr=%h count=%0d",
					got.status, got.block_address, got.free_count)));
			end else begin
				exp = expected_q.pop_front();
				if (got.status !== exp.status || got.block_address !== exp.block_address ||
					got.free_count !== exp.free_count)
					flag($sformatf("response %0d: exp %s, got %s", responses,
						$sformatf("st=%0d addr=%h count=%0d",
							exp.status, exp.block_address, exp.free_count),
						$sformatf("st=%0d addr=%h count=%0d",
							got.status, got.block_address, got.free_count)));
			end
			responses++;
		endfunction
	endclass

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [23:0]                s_tdata  = '0;  // byte_address
	logic [1:0]                 s_tuser  = '0;  // operation
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [39:0]                m_tdata;        // block_address, free_count, zero pad
	logic [2:0]                 m_tuser;        // status
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [pfa_pkg::APB_AW-1:0] paddr    = '0;
	logic [31:0]                pwdata   = '0;
	logic [31:0]                prdata;
	logic                       pready;

	frame_ledger ledger = new();
	bit          long_hold;
	int unsigned burst_left;
	int unsigned squeeze_left;
	int unsigned settings;

	page_frame_allocator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_response({m_tuser, m_tdata[23:0], m_tdata[36:24]});
	end

	// response side: stall patterns, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		hold_left = 0;
		mode_left = 0;
		mode      = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d responses outstanding", ledger.expected_q.size());
		$display("status: fail");
		$finish;
	end

	task automatic send_request(logic [pfa_pkg::OP_W-1:0] op, logic [pfa_pkg::ADDR_W-1:0] addr);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= addr;
		do @(posedge clk); while (!s_tready);
		ledger.note_request(op, addr);
		if (squeeze_left > 0) begin
			squeeze_left--;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (ledger.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write reserved_blocks, then read it straight back
	task automatic set_reservation(logic [pfa_pkg::COUNT_W-1:0] v);
		logic [31:0] word;
		word = {19'd0, v};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {pfa_pkg::REG_RESERVED, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.reserved = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== word)
			ledger.flag($sformatf("reserved_blocks read %h, wrote %h", prdata, word));
		psel    <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [pfa_pkg::ADDR_W-1:0] a;
		pick = $urandom_range(0, 99);
		a    = 24'($urandom());
		if (pick < 45)
			send_request(pfa_pkg::OP_ALLOC, a);
		else if (pick < 80 && ledger.held.size() > 0)
			send_request(pfa_pkg::OP_FREE,
				24'(ledger.held[$urandom_range(0, ledger.held.size() - 1)] * BLK_BYTES));
		else if (pick < 88)
			send_request(pfa_pkg::OP_FREE, a & ~24'(BLK_BYTES - 1));
		else if (pick < 96)
			send_request(pfa_pkg::OP_FREE, a);
		else if (pick < 99)
			send_request(OP_UNUSED, a);
		else
			send_request(pfa_pkg::OP_INIT, a);
	endtask

	task automatic run_phase(logic [pfa_pkg::COUNT_W-1:0] v, int unsigned count, bit squeeze);
		int unsigned k;
		settle();
		set_reservation(v);
		send_request(pfa_pkg::OP_INIT, 24'($urandom()));
		if (squeeze) begin
			long_hold    = 1'b1;
			squeeze_left = 40;
		end
		for (k = 0; k < count; k++)
			random_request();
	endtask

	initial begin
		int unsigned p;
		int unsigned sel;
		logic [pfa_pkg::COUNT_W-1:0] v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any initialize: nothing free, nothing occupied
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'h000123);
		send_request(OP_UNUSED, 24'hFFFFFF);
		send_request(pfa_pkg::OP_FREE, 24'hFFF000);

		// reservation at its reset value
		send_request(pfa_pkg::OP_INIT, 24'h000000);
		send_request(pfa_pkg::OP_ALLOC, 24'hFFFFFF);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'hFFF000);
		send_request(pfa_pkg::OP_FREE, 24'hFFF000);
		send_request(pfa_pkg::OP_FREE, 24'h000000);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(OP_UNUSED, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'h800001);
		send_request(pfa_pkg::OP_FREE, 24'h000FFF);

		// one block left, then exhausted
		settle();
		set_reservation(13'd4095);
		send_request(pfa_pkg::OP_INIT, 24'hFFFFFF);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'hFFF000);
		send_request(pfa_pkg::OP_FREE, 24'hFFE000);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);

		// oversized reservation saturates
		settle();
		set_reservation(13'h1FFF);
		send_request(pfa_pkg::OP_INIT, 24'h000000);
		send_request(pfa_pkg::OP_ALLOC, 24'h000000);
		send_request(pfa_pkg::OP_FREE, 24'h000000);

		p = 0;
		while (ledger.requests < N_ITEMS) begin
			sel = $urandom_range(0, 5);
			if (p == 0)
				v = 13'd0;
			else if (p == 1)
				v = 13'd4096;
			else if (sel < 2)
				v = 13'(4096 - $urandom_range(1, 64));
			else if (sel < 4)
				v = 13'($urandom_range(0, 4096));
			else if (sel == 4)
				v = ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'h1FFF;
			else
				v = 13'($urandom_range(0, 8191));
			run_phase(v, 55, p == 2);
			p++;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d requests under %0d reservation settings with random stalls",
			ledger.requests, settings + 1);
		$display("outcomes: ok %0d, out of memory %0d, already free %0d, misaligned %0d",
			ledger.status_seen[pfa_pkg::ST_OK], ledger.status_seen[pfa_pkg::ST_OOM],
			ledger.status_seen[pfa_pkg::ST_ALREADY_FREE],
			ledger.status_seen[pfa_pkg::ST_MISALIGNED]);
		$display("mismatches %0d", ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
